/* rtl/rcd_pkg.sv */
// ----------------------------------------------------------------------------
// Reversible circular deque package
// Sizes, field widths, operation and status codes, and ring pointer helpers
// shared by the interfaces and the deque core.
// ----------------------------------------------------------------------------
package rcd_pkg;

  // Store geometry.
  localparam int CAPACITY      = 1024;
  localparam int ELEMENT_WIDTH = 32;
  localparam int PTR_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  // Field widths of the request and result channels.
  localparam int MODE_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;

  // Width used to compare a request index against the element count.
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic [PTR_W:0]           ptr_wide_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [MODE_W-1:0]        mode_t;
  typedef logic [STATUS_W-1:0]      status_t;

  // Operation codes.
  localparam mode_t OP_PUSH_BACK  = 4'd0;
  localparam mode_t OP_PUSH_FRONT = 4'd1;
  localparam mode_t OP_POP_BACK   = 4'd2;
  localparam mode_t OP_POP_FRONT  = 4'd3;
  localparam mode_t OP_READ       = 4'd4;
  localparam mode_t OP_WRITE      = 4'd5;
  localparam mode_t OP_REVERSE    = 4'd6;
  localparam mode_t OP_SEARCH     = 4'd7;
  localparam mode_t OP_CLEAR      = 4'd8;

  // Status codes.
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_RANGE    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  function automatic ptr_t ring_inc(input ptr_t p);
    return (p == ptr_t'(CAPACITY - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ring_dec(input ptr_t p);
    return (p == '0) ? ptr_t'(CAPACITY - 1) : p - ptr_t'(1);
  endfunction

  // Physical slot of a logical offset from the front, wrapping in either
  // direction. The offset is always below CAPACITY.
  function automatic ptr_t slot_of(input ptr_t front, input ptr_t off, input logic rev);
    ptr_wide_t sum;
    if (!rev) begin
      sum = {1'b0, front} + {1'b0, off};
      if (sum >= ptr_wide_t'(CAPACITY)) begin
        sum = sum - ptr_wide_t'(CAPACITY);
      end
    end else if (off > front) begin
      sum = {1'b0, front} + ptr_wide_t'(CAPACITY) - {1'b0, off};
    end else begin
      sum = {1'b0, front} - {1'b0, off};
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

/* rtl/rcd_if.sv */
// ----------------------------------------------------------------------------
// Reversible circular deque channels
// Valid/ready request and result channels of the deque core.
// ----------------------------------------------------------------------------
interface rcd_req_if;
  logic                        valid;
  logic                        ready;
  logic [rcd_pkg::MODE_W-1:0]  mode;
  logic [rcd_pkg::VALUE_W-1:0] value;
  logic [rcd_pkg::INDEX_W-1:0] index;

  modport source (output valid, output mode, output value, output index, input ready);
  modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

interface rcd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rcd_pkg::DATA_W-1:0]   data;
  logic [rcd_pkg::POS_W-1:0]    position;
  logic [rcd_pkg::STATUS_W-1:0] status;
  logic [rcd_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output data, output position, output status, output count,
                  input ready);
  modport sink   (input valid, input data, input position, input status, input count,
                  output ready);
endinterface

/* rtl/reversible_circular_deque_core.sv */
// ----------------------------------------------------------------------------
// Reversible circular deque core
// Fixed-capacity ring deque with a reverse flag, index access and search.
// ----------------------------------------------------------------------------
// Each request carries one operation and yields exactly one result. For push,
// pop, write, reverse, clear and unused codes the deque state is updated on
// the accepting edge and the result is then loaded into the output register.
// A read takes its data from the registered read port of the element store.
// A search walks the store one entry per cycle through its single read port,
// comparing entries in logical order up to the first match, or over the full
// count when nothing matches; a search of an empty deque does not walk the
// store. A new request is taken as soon as the core is idle, even while the
// previous result still waits in the output register; the core only holds a
// finished result back when that register is still occupied.
// The element store has no reset; entries hold garbage until pushed or
// written, and the pointers and count never let a read reach such an entry.
// ----------------------------------------------------------------------------
module reversible_circular_deque_core (
  input  logic      clk,
  input  logic      rst_n,
  rcd_req_if.sink   in_req,
  rcd_rsp_if.source out_rsp
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Deque control state.
  logic [1:0]    state_r, state_nxt;
  rcd_pkg::ptr_t front_r, front_nxt;
  rcd_pkg::ptr_t back_r, back_nxt;
  rcd_pkg::cnt_t cnt_r, cnt_nxt;
  logic          rev_r, rev_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Search walk.
  rcd_pkg::ptr_t srch_ptr_r, srch_ptr_nxt;
  rcd_pkg::ptr_t srch_i_r, srch_i_nxt;
  rcd_pkg::elem_t key_r, key_nxt;

  // Pending result, waiting for the output register.
  logic                         res_rd_r, res_rd_nxt;
  logic [rcd_pkg::POS_W-1:0]    res_pos_r, res_pos_nxt;
  rcd_pkg::status_t             res_status_r, res_status_nxt;
  logic [rcd_pkg::COUNT_W-1:0]  res_count_r, res_count_nxt;

  // Output register.
  logic [rcd_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [rcd_pkg::POS_W-1:0]    out_pos_r, out_pos_nxt;
  rcd_pkg::status_t             out_status_r, out_status_nxt;
  logic [rcd_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  // Element store with one write and one registered read port.
  rcd_pkg::elem_t mem [rcd_pkg::CAPACITY];
  rcd_pkg::elem_t mem_q_r;
  logic           wr_en;
  rcd_pkg::ptr_t  wr_addr;
  rcd_pkg::elem_t wr_data;
  logic           rd_en;
  rcd_pkg::ptr_t  rd_addr;

  logic           req_acc;
  logic           out_free;
  logic           full;
  logic           empty;
  logic           idx_bad;
  rcd_pkg::elem_t elem_in;
  rcd_pkg::ptr_t  slot;
  rcd_pkg::ptr_t  step_ptr;
  rcd_pkg::cnt_t  srch_next_i;

  assign in_req.ready     = (state_r == S_IDLE);
  assign req_acc          = in_req.valid && in_req.ready;
  assign out_free         = !out_valid_r || out_rsp.ready;

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.data     = out_data_r;
  assign out_rsp.position = out_pos_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.count    = out_count_r;

  assign full    = (cnt_r == rcd_pkg::cnt_t'(rcd_pkg::CAPACITY));
  assign empty   = (cnt_r == '0);
  assign idx_bad = (rcd_pkg::CMP_W'(in_req.index) >= rcd_pkg::CMP_W'(cnt_r));
  assign elem_in = rcd_pkg::ELEMENT_WIDTH'(in_req.value);

  // The slot is only used when the index is below the count, so the index
  // always fits the pointer width there.
  assign slot = rcd_pkg::slot_of(front_r, rcd_pkg::PTR_W'(in_req.index), rev_r);

  // Next entry of a search walk, in the logical direction of the deque.
  assign step_ptr    = rev_r ? rcd_pkg::ring_dec(srch_ptr_r) : rcd_pkg::ring_inc(srch_ptr_r);
  assign srch_next_i = rcd_pkg::CNT_W'(srch_i_r) + rcd_pkg::cnt_t'(1);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    cnt_nxt        = cnt_r;
    rev_nxt        = rev_r;
    srch_ptr_nxt   = srch_ptr_r;
    srch_i_nxt     = srch_i_r;
    key_nxt        = key_r;
    res_rd_nxt     = res_rd_r;
    res_pos_nxt    = res_pos_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_data_nxt   = out_data_r;
    out_pos_nxt    = out_pos_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = slot;
    wr_data        = elem_in;
    rd_en          = 1'b0;
    rd_addr        = slot;

    unique case (state_r)
      S_IDLE: begin
        if (req_acc) begin
          state_nxt      = S_DONE;
          res_rd_nxt     = 1'b0;
          res_pos_nxt    = '0;
          res_status_nxt = rcd_pkg::ST_OK;
          unique case (in_req.mode)
            rcd_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res_status_nxt = rcd_pkg::ST_FULL;
              end else begin
                back_nxt = rev_r ? rcd_pkg::ring_dec(back_r) : rcd_pkg::ring_inc(back_r);
                wr_en    = 1'b1;
                wr_addr  = back_nxt;
                cnt_nxt  = cnt_r + rcd_pkg::cnt_t'(1);
              end
            end
            rcd_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res_status_nxt = rcd_pkg::ST_FULL;
              end else begin
                front_nxt = rev_r ? rcd_pkg::ring_inc(front_r) : rcd_pkg::ring_dec(front_r);
                wr_en     = 1'b1;
                wr_addr   = front_nxt;
                cnt_nxt   = cnt_r + rcd_pkg::cnt_t'(1);
              end
            end
            rcd_pkg::OP_POP_BACK: begin
              if (empty) begin
                res_status_nxt = rcd_pkg::ST_EMPTY;
              end else begin
                back_nxt = rev_r ? rcd_pkg::ring_inc(back_r) : rcd_pkg::ring_dec(back_r);
                cnt_nxt  = cnt_r - rcd_pkg::cnt_t'(1);
              end
            end
            rcd_pkg::OP_POP_FRONT: begin
              if (empty) begin
                res_status_nxt = rcd_pkg::ST_EMPTY;
              end else begin
                front_nxt = rev_r ? rcd_pkg::ring_dec(front_r) : rcd_pkg::ring_inc(front_r);
                cnt_nxt   = cnt_r - rcd_pkg::cnt_t'(1);
              end
            end
            rcd_pkg::OP_READ: begin
              if (idx_bad) begin
                res_status_nxt = rcd_pkg::ST_RANGE;
              end else begin
                // The data arrives from the store in the next cycle.
                rd_en      = 1'b1;
                rd_addr    = slot;
                res_rd_nxt = 1'b1;
              end
            end
            rcd_pkg::OP_WRITE: begin
              if (idx_bad) begin
                res_status_nxt = rcd_pkg::ST_RANGE;
              end else begin
                wr_en   = 1'b1;
                wr_addr = slot;
              end
            end
            rcd_pkg::OP_REVERSE: begin
              front_nxt = back_r;
              back_nxt  = front_r;
              rev_nxt   = !rev_r;
            end
            rcd_pkg::OP_SEARCH: begin
              key_nxt = elem_in;
              if (empty) begin
                res_status_nxt = rcd_pkg::ST_NOTFOUND;
              end else begin
                // Start the walk at the front; the compare happens once the
                // first entry comes back from the store.
                rd_en        = 1'b1;
                rd_addr      = front_r;
                srch_ptr_nxt = front_r;
                srch_i_nxt   = '0;
                state_nxt    = S_SRCH;
              end
            end
            rcd_pkg::OP_CLEAR: begin
              front_nxt = '0;
              back_nxt  = rcd_pkg::ptr_t'(rcd_pkg::CAPACITY - 1);
              cnt_nxt   = '0;
              rev_nxt   = 1'b0;
            end
            default: begin
              // Unused codes leave everything as it is and report success.
            end
          endcase
          res_count_nxt = rcd_pkg::COUNT_W'(cnt_nxt);
        end
      end

      S_SRCH: begin
        // mem_q_r holds the entry at logical position srch_i_r.
        if (mem_q_r == key_r) begin
          res_pos_nxt    = rcd_pkg::POS_W'(srch_i_r);
          res_status_nxt = rcd_pkg::ST_OK;
          state_nxt      = S_DONE;
        end else if (srch_next_i == cnt_r) begin
          res_pos_nxt    = '0;
          res_status_nxt = rcd_pkg::ST_NOTFOUND;
          state_nxt      = S_DONE;
        end else begin
          rd_en        = 1'b1;
          rd_addr      = step_ptr;
          srch_ptr_nxt = step_ptr;
          srch_i_nxt   = srch_i_r + rcd_pkg::ptr_t'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_rd_r ? rcd_pkg::DATA_W'(mem_q_r) : '0;
          out_pos_nxt    = res_pos_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = res_count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= rcd_pkg::ptr_t'(rcd_pkg::CAPACITY - 1);
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      cnt_r       <= cnt_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    srch_ptr_r   <= srch_ptr_nxt;
    srch_i_r     <= srch_i_nxt;
    key_r        <= key_nxt;
    res_rd_r     <= res_rd_nxt;
    res_pos_r    <= res_pos_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    out_data_r   <= out_data_nxt;
    out_pos_r    <= out_pos_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Element store. Writes happen only on an accepting edge and the core passes
  // through its done state before it accepts the next request, so a read never
  // meets a write to the same entry in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // The count never goes beyond the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rcd_pkg::cnt_t'(rcd_pkg::CAPACITY))
    else $error("element count above capacity");

  // An accepted request always takes the core out of the idle state.
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc |=> !in_req.ready)
    else $error("request accepted in back-to-back cycles");

  // A search walk only runs over a non-empty deque.
  a_srch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (cnt_r != '0))
    else $error("search walk over an empty deque");

  // A new result only appears after the core finished a request.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result appeared without a finished request");

  // The store is never written while a search walks it.
  a_srch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> !wr_en)
    else $error("store written during a search");

endmodule
